>>> rtl/tnt_pkg.sv
package tnt_pkg;

   localparam int INDEX_BITS_DEF = 16;
   localparam int IDX_W          = 16;
   localparam int POS_W          = 16;
   localparam int UV_W           = 16;
   localparam int COMP_W         = 16;
   localparam int EDGE_W         = 17;
   localparam int PROD_W         = 34;
   localparam int DIFF_W         = 35;
   localparam int MAG_W          = 35;
   localparam int LEAD_W         = 6;
   localparam int SHIFT_W        = 5;
   localparam int TOP_POS        = 29;
   localparam int NRM_W          = 30;
   localparam int SQ_W           = 60;
   localparam int SUM_W          = 62;
   localparam int ROOT_W         = 31;
   localparam int REM_W          = 34;
   localparam int SQRT_STEPS     = 31;
   localparam int FRAC_BITS      = 14;
   localparam int NUM_W          = 45;
   localparam int Q_W            = 15;
   localparam int DIV_STEPS      = 15;
   localparam int UNIT_ONE       = 16384;
   localparam int QUEUE_DEPTH    = 2;

   localparam int ADDR_W         = 3;
   localparam int DATA_W         = 32;
   localparam logic [0:0] REG_NORMALS_ENABLE = 1'b0;

   typedef struct packed {
      logic [IDX_W-1:0]            idx_a;
      logic [IDX_W-1:0]            idx_b;
      logic [IDX_W-1:0]            idx_c;
      logic [2:0][MAG_W-1:0]       n_mag;
      logic [2:0]                  n_neg;
      logic [2:0][MAG_W-1:0]       t_mag;
      logic [2:0]                  t_neg;
      logic                        degenerate;
   } tri_type;

endpackage

>>> rtl/tnt_front.sv
module tnt_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [tnt_pkg::IDX_W-1:0]            vertex_index_a,
   input  logic [tnt_pkg::IDX_W-1:0]            vertex_index_b,
   input  logic [tnt_pkg::IDX_W-1:0]            vertex_index_c,
   input  logic [3*tnt_pkg::POS_W-1:0]          position_a,
   input  logic [3*tnt_pkg::POS_W-1:0]          position_b,
   input  logic [3*tnt_pkg::POS_W-1:0]          position_c,
   input  logic [2*tnt_pkg::UV_W-1:0]           texcoord_a,
   input  logic [2*tnt_pkg::UV_W-1:0]           texcoord_b,
   input  logic [2*tnt_pkg::UV_W-1:0]           texcoord_c,
   input  logic                                 q_full,
   output logic                                 busy,
   output logic                                 push,
   output tnt_pkg::tri_type                     push_data
);

   localparam int EW = tnt_pkg::EDGE_W;
   localparam int PW = tnt_pkg::PROD_W;
   localparam int DW = tnt_pkg::DIFF_W;
   localparam int UW = tnt_pkg::UV_W;
   localparam int XW = tnt_pkg::POS_W;

   logic adv;

   // stage 1: edges and uv deltas
   logic                     s1_valid_ff;
   logic [tnt_pkg::IDX_W-1:0] s1_idx_ff [3];
   logic signed [EW-1:0]     s1_e1_ff [3];
   logic signed [EW-1:0]     s1_e2_ff [3];
   logic signed [EW-1:0]     s1_e1_in [3];
   logic signed [EW-1:0]     s1_e2_in [3];
   logic signed [EW-1:0]     s1_du1_ff, s1_dv1_ff, s1_du2_ff, s1_dv2_ff;
   logic signed [EW-1:0]     s1_du1_in, s1_dv1_in, s1_du2_in, s1_dv2_in;

   // stage 2: products
   logic                     s2_valid_ff;
   logic [tnt_pkg::IDX_W-1:0] s2_idx_ff [3];
   logic signed [PW-1:0]     s2_c1_ff [3];
   logic signed [PW-1:0]     s2_c2_ff [3];
   logic signed [PW-1:0]     s2_t1_ff [3];
   logic signed [PW-1:0]     s2_t2_ff [3];
   logic signed [PW-1:0]     s2_d1_ff, s2_d2_ff;

   // stage 3: differences
   logic                     s3_valid_ff;
   logic [tnt_pkg::IDX_W-1:0] s3_idx_ff [3];
   logic signed [DW-1:0]     s3_n_ff [3];
   logic signed [DW-1:0]     s3_t_ff [3];
   logic signed [DW-1:0]     s3_det_ff;

   // stage 4: magnitudes and signs
   logic                     s4_valid_ff;
   tnt_pkg::tri_type         s4_data_ff;
   tnt_pkg::tri_type         s4_data_in;

   assign adv  = !(s4_valid_ff && q_full);
   assign busy = !adv;
   assign push = s4_valid_ff && !q_full;
   assign push_data = s4_data_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_e1_in[i] = {position_b[XW*i+XW-1], position_b[XW*i +: XW]}
                     - {position_a[XW*i+XW-1], position_a[XW*i +: XW]};
         s1_e2_in[i] = {position_c[XW*i+XW-1], position_c[XW*i +: XW]}
                     - {position_a[XW*i+XW-1], position_a[XW*i +: XW]};
      end
      s1_du1_in = {1'b0, texcoord_b[UW-1:0]}    - {1'b0, texcoord_a[UW-1:0]};
      s1_dv1_in = {1'b0, texcoord_b[2*UW-1:UW]} - {1'b0, texcoord_a[2*UW-1:UW]};
      s1_du2_in = {1'b0, texcoord_c[UW-1:0]}    - {1'b0, texcoord_a[UW-1:0]};
      s1_dv2_in = {1'b0, texcoord_c[2*UW-1:UW]} - {1'b0, texcoord_a[2*UW-1:UW]};
   end

   always_comb begin
      s4_data_in.idx_a = s3_idx_ff[0];
      s4_data_in.idx_b = s3_idx_ff[1];
      s4_data_in.idx_c = s3_idx_ff[2];
      for (int i = 0; i < 3; i++) begin
         s4_data_in.n_neg[i] = s3_n_ff[i][DW-1];
         s4_data_in.n_mag[i] = s3_n_ff[i][DW-1] ? tnt_pkg::MAG_W'(-s3_n_ff[i])
                                                : tnt_pkg::MAG_W'(s3_n_ff[i]);
         s4_data_in.t_neg[i] = s3_t_ff[i][DW-1] ^ s3_det_ff[DW-1];
         s4_data_in.t_mag[i] = s3_t_ff[i][DW-1] ? tnt_pkg::MAG_W'(-s3_t_ff[i])
                                                : tnt_pkg::MAG_W'(s3_t_ff[i]);
      end
      s4_data_in.degenerate = (s3_det_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff[0] <= vertex_index_a;
         s1_idx_ff[1] <= vertex_index_b;
         s1_idx_ff[2] <= vertex_index_c;
         s1_e1_ff     <= s1_e1_in;
         s1_e2_ff     <= s1_e2_in;
         s1_du1_ff    <= s1_du1_in;
         s1_dv1_ff    <= s1_dv1_in;
         s1_du2_ff    <= s1_du2_in;
         s1_dv2_ff    <= s1_dv2_in;

         s2_idx_ff   <= s1_idx_ff;
         s2_c1_ff[0] <= s1_e1_ff[1] * s1_e2_ff[2];
         s2_c2_ff[0] <= s1_e1_ff[2] * s1_e2_ff[1];
         s2_c1_ff[1] <= s1_e1_ff[2] * s1_e2_ff[0];
         s2_c2_ff[1] <= s1_e1_ff[0] * s1_e2_ff[2];
         s2_c1_ff[2] <= s1_e1_ff[0] * s1_e2_ff[1];
         s2_c2_ff[2] <= s1_e1_ff[1] * s1_e2_ff[0];
         for (int i = 0; i < 3; i++) begin
            s2_t1_ff[i] <= s1_dv2_ff * s1_e1_ff[i];
            s2_t2_ff[i] <= s1_dv1_ff * s1_e2_ff[i];
         end
         s2_d1_ff <= s1_du1_ff * s1_dv2_ff;
         s2_d2_ff <= s1_du2_ff * s1_dv1_ff;

         s3_idx_ff <= s2_idx_ff;
         for (int i = 0; i < 3; i++) begin
            s3_n_ff[i] <= DW'(s2_c1_ff[i]) - DW'(s2_c2_ff[i]);
            s3_t_ff[i] <= DW'(s2_t1_ff[i]) - DW'(s2_t2_ff[i]);
         end
         s3_det_ff <= DW'(s2_d1_ff) - DW'(s2_d2_ff);

         s4_data_ff <= s4_data_in;
      end
   end

endmodule

>>> rtl/tnt_queue.sv
module tnt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tnt_pkg::tri_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output tnt_pkg::tri_type head
);

   localparam int DEPTH = tnt_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tnt_pkg::tri_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/tnt_norm.sv
module tnt_norm #(
   parameter int TAG_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [2:0][tnt_pkg::MAG_W-1:0]     in_mag,
   input  logic [2:0]                         in_neg,
   input  logic [TAG_W-1:0]                   in_tag,
   output logic                               out_valid,
   output logic [3*tnt_pkg::COMP_W-1:0]       out_packed,
   output logic [TAG_W-1:0]                   out_tag
);

   localparam int MW  = tnt_pkg::MAG_W;
   localparam int NW  = tnt_pkg::NRM_W;
   localparam int SW  = tnt_pkg::SUM_W;
   localparam int RW  = tnt_pkg::ROOT_W;
   localparam int EW  = tnt_pkg::REM_W;
   localparam int UW  = tnt_pkg::NUM_W;
   localparam int QW  = tnt_pkg::Q_W;
   localparam int CW  = tnt_pkg::COMP_W;
   localparam int SQN = tnt_pkg::SQRT_STEPS;
   localparam int DVN = tnt_pkg::DIV_STEPS;

   // A: leading one of the largest magnitude
   logic [MW-1:0]                  top_in;
   logic [tnt_pkg::LEAD_W-1:0]     lead_in;
   logic                           a_right_in;
   logic [tnt_pkg::SHIFT_W-1:0]    a_amt_in;
   logic                           a_valid_ff;
   logic [2:0][MW-1:0]             a_mag_ff;
   logic [2:0]                     a_neg_ff;
   logic                           a_zero_ff;
   logic                           a_right_ff;
   logic [tnt_pkg::SHIFT_W-1:0]    a_amt_ff;
   logic [TAG_W-1:0]               a_tag_ff;

   // B: aligned magnitudes
   logic                           b_valid_ff;
   logic [2:0][NW-1:0]             b_m_ff, b_m_in;
   logic [2:0]                     b_neg_ff;
   logic                           b_zero_ff;
   logic [TAG_W-1:0]               b_tag_ff;

   // C: squares
   logic                           c_valid_ff;
   logic [2:0][tnt_pkg::SQ_W-1:0]  c_sq_ff;
   logic [2:0][NW-1:0]             c_m_ff;
   logic [2:0]                     c_neg_ff;
   logic                           c_zero_ff;
   logic [TAG_W-1:0]               c_tag_ff;

   // square root, one result bit per stage
   logic                           s_valid_ff [SQN+1];
   logic [SW-1:0]                  s_rad_ff   [SQN+1];
   logic [EW-1:0]                  s_rem_ff   [SQN+1];
   logic [RW-1:0]                  s_root_ff  [SQN+1];
   logic [2:0][NW-1:0]             s_m_ff     [SQN+1];
   logic [2:0]                     s_neg_ff   [SQN+1];
   logic                           s_zero_ff  [SQN+1];
   logic [TAG_W-1:0]               s_tag_ff   [SQN+1];

   // restoring divide, one quotient bit per stage
   logic                           d_valid_ff [DVN+1];
   logic [2:0][UW-1:0]             d_num_ff   [DVN+1];
   logic [2:0][QW-1:0]             d_q_ff     [DVN+1];
   logic [RW-1:0]                  d_div_ff   [DVN+1];
   logic [2:0]                     d_neg_ff   [DVN+1];
   logic                           d_zero_ff  [DVN+1];
   logic [TAG_W-1:0]               d_tag_ff   [DVN+1];

   logic                           h_valid_ff;
   logic [3*CW-1:0]                h_packed_ff, h_packed_in;
   logic [TAG_W-1:0]               h_tag_ff;

   always_comb begin
      top_in  = in_mag[0] | in_mag[1] | in_mag[2];
      lead_in = '0;
      for (int b = 0; b < MW; b++) begin
         if (top_in[b]) begin
            lead_in = tnt_pkg::LEAD_W'(b);
         end
      end
      if (lead_in >= tnt_pkg::LEAD_W'(tnt_pkg::TOP_POS)) begin
         a_right_in = 1'b1;
         a_amt_in   = tnt_pkg::SHIFT_W'(lead_in - tnt_pkg::LEAD_W'(tnt_pkg::TOP_POS));
      end else begin
         a_right_in = 1'b0;
         a_amt_in   = tnt_pkg::SHIFT_W'(tnt_pkg::LEAD_W'(tnt_pkg::TOP_POS) - lead_in);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_m_in[i] = a_right_ff ? NW'(a_mag_ff[i] >> a_amt_ff)
                                : NW'(a_mag_ff[i] << a_amt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         s_valid_ff[0] <= 1'b0;
      end else begin
         a_valid_ff    <= in_valid;
         b_valid_ff    <= a_valid_ff;
         c_valid_ff    <= b_valid_ff;
         s_valid_ff[0] <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_mag_ff   <= in_mag;
      a_neg_ff   <= in_neg;
      a_zero_ff  <= (top_in == '0);
      a_right_ff <= a_right_in;
      a_amt_ff   <= a_amt_in;
      a_tag_ff   <= in_tag;

      b_m_ff    <= b_m_in;
      b_neg_ff  <= a_neg_ff;
      b_zero_ff <= a_zero_ff;
      b_tag_ff  <= a_tag_ff;

      for (int i = 0; i < 3; i++) begin
         c_sq_ff[i] <= b_m_ff[i] * b_m_ff[i];
      end
      c_m_ff    <= b_m_ff;
      c_neg_ff  <= b_neg_ff;
      c_zero_ff <= b_zero_ff;
      c_tag_ff  <= b_tag_ff;

      s_rad_ff[0]  <= SW'(c_sq_ff[0]) + SW'(c_sq_ff[1]) + SW'(c_sq_ff[2]);
      s_rem_ff[0]  <= '0;
      s_root_ff[0] <= '0;
      s_m_ff[0]    <= c_m_ff;
      s_neg_ff[0]  <= c_neg_ff;
      s_zero_ff[0] <= c_zero_ff;
      s_tag_ff[0]  <= c_tag_ff;
   end

   for (genvar k = 0; k < SQN; k++) begin : g_sqrt
      logic [EW-1:0] rem_in;
      logic [EW-1:0] trial_in;
      logic          ge_in;

      always_comb begin
         rem_in   = {s_rem_ff[k][EW-3:0], s_rad_ff[k][SW-1 -: 2]};
         trial_in = {EW'(s_root_ff[k]) << 2} | EW'(1);
         ge_in    = (rem_in >= trial_in);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            s_valid_ff[k+1] <= 1'b0;
         end else begin
            s_valid_ff[k+1] <= s_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         s_rem_ff[k+1]  <= ge_in ? rem_in - trial_in : rem_in;
         s_root_ff[k+1] <= {s_root_ff[k][RW-2:0], ge_in};
         s_rad_ff[k+1]  <= s_rad_ff[k] << 2;
         s_m_ff[k+1]    <= s_m_ff[k];
         s_neg_ff[k+1]  <= s_neg_ff[k];
         s_zero_ff[k+1] <= s_zero_ff[k];
         s_tag_ff[k+1]  <= s_tag_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff[0] <= 1'b0;
      end else begin
         d_valid_ff[0] <= s_valid_ff[SQN];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         d_num_ff[0][i] <= (UW'(s_m_ff[SQN][i]) << tnt_pkg::FRAC_BITS)
                         + UW'(s_root_ff[SQN] >> 1);
      end
      d_q_ff[0]    <= '0;
      d_div_ff[0]  <= s_root_ff[SQN];
      d_neg_ff[0]  <= s_neg_ff[SQN];
      d_zero_ff[0] <= s_zero_ff[SQN];
      d_tag_ff[0]  <= s_tag_ff[SQN];
   end

   for (genvar j = 0; j < DVN; j++) begin : g_div
      logic [UW-1:0]      sub_in;
      logic [2:0]         ge_in;
      logic [2:0][UW-1:0] num_in;

      always_comb begin
         sub_in = UW'(d_div_ff[j]) << (QW - 1 - j);
         for (int i = 0; i < 3; i++) begin
            ge_in[i]  = (d_num_ff[j][i] >= sub_in);
            num_in[i] = ge_in[i] ? d_num_ff[j][i] - sub_in : d_num_ff[j][i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[j+1] <= 1'b0;
         end else begin
            d_valid_ff[j+1] <= d_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         d_num_ff[j+1] <= num_in;
         for (int i = 0; i < 3; i++) begin
            d_q_ff[j+1][i] <= {d_q_ff[j][i][QW-2:0], ge_in[i]};
         end
         d_div_ff[j+1]  <= d_div_ff[j];
         d_neg_ff[j+1]  <= d_neg_ff[j];
         d_zero_ff[j+1] <= d_zero_ff[j];
         d_tag_ff[j+1]  <= d_tag_ff[j];
      end
   end

   always_comb begin
      logic [CW-1:0] mag;
      h_packed_in = '0;
      for (int i = 0; i < 3; i++) begin
         mag = (CW'(d_q_ff[DVN][i]) > CW'(tnt_pkg::UNIT_ONE)) ? CW'(tnt_pkg::UNIT_ONE)
                                                              : CW'(d_q_ff[DVN][i]);
         if (!d_zero_ff[DVN]) begin
            h_packed_in[CW*i +: CW] = d_neg_ff[DVN][i] ? CW'(-mag) : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= d_valid_ff[DVN];
      end
   end

   always_ff @(posedge clock) begin
      h_packed_ff <= h_packed_in;
      h_tag_ff    <= d_tag_ff[DVN];
   end

   assign out_valid  = h_valid_ff;
   assign out_packed = h_packed_ff;
   assign out_tag    = h_tag_ff;

endmodule

>>> rtl/triangle_normal_tangent.sv
// Triangle face normal and tangent unit. A triangle is taken on any cycle where
// start is high and busy is low; one triangle per cycle is sustained while busy stays
// low. Each result appears on the rsp_ ports for a single cycle marked by rsp_valid,
// after its triangle has passed through 4 setup/product stages, a 2-entry queue,
// then a normalizer pipeline dominated by a 31-stage square root and a 15-stage
// divider. The receiver cannot stall; results must be captured when rsp_valid
// is high. Register normals_enable sits at byte address 0 and resets to 1.
module triangle_normal_tangent #(
   parameter int INDEX_BITS = tnt_pkg::INDEX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                start,
   output logic                                busy,
   input  logic [tnt_pkg::IDX_W-1:0]           req_vertex_index_a,
   input  logic [tnt_pkg::IDX_W-1:0]           req_vertex_index_b,
   input  logic [tnt_pkg::IDX_W-1:0]           req_vertex_index_c,
   input  logic [3*tnt_pkg::POS_W-1:0]         req_position_a,
   input  logic [3*tnt_pkg::POS_W-1:0]         req_position_b,
   input  logic [3*tnt_pkg::POS_W-1:0]         req_position_c,
   input  logic [2*tnt_pkg::UV_W-1:0]          req_texcoord_a,
   input  logic [2*tnt_pkg::UV_W-1:0]          req_texcoord_b,
   input  logic [2*tnt_pkg::UV_W-1:0]          req_texcoord_c,

   output logic                                rsp_valid,
   output logic [tnt_pkg::IDX_W-1:0]           rsp_out_index_a,
   output logic [tnt_pkg::IDX_W-1:0]           rsp_out_index_b,
   output logic [tnt_pkg::IDX_W-1:0]           rsp_out_index_c,
   output logic [3*tnt_pkg::COMP_W-1:0]        rsp_unit_normal,
   output logic [3*tnt_pkg::COMP_W-1:0]        rsp_unit_tangent,
   output logic                                rsp_tangent_degenerate,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tnt_pkg::ADDR_W-1:0]          paddr,
   input  logic [tnt_pkg::DATA_W-1:0]          pwdata,
   output logic [tnt_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);

   localparam logic [tnt_pkg::IDX_W-1:0] IDX_MASK =
      tnt_pkg::IDX_W'(32'hFFFF_FFFF >> (32 - INDEX_BITS));
   localparam int TAG_W = 3 * tnt_pkg::IDX_W;

   logic                  normals_enable_ff, normals_enable_in;
   logic                  accept;
   logic                  q_full, q_empty, push, pop;
   tnt_pkg::tri_type      push_data, head;
   logic                  n_valid, t_valid;
   logic [3*tnt_pkg::COMP_W-1:0] n_packed, t_packed;
   logic [TAG_W-1:0]      n_tag;
   logic                  t_tag;

   assign accept = start && !busy;
   assign pop    = !q_empty;
   assign pready = 1'b1;
   assign prdata = {{(tnt_pkg::DATA_W-1){1'b0}}, normals_enable_ff};

   always_comb begin
      normals_enable_in = normals_enable_ff;
      if (psel && penable && pwrite
          && paddr[tnt_pkg::ADDR_W-1] == tnt_pkg::REG_NORMALS_ENABLE) begin
         normals_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normals_enable_ff <= 1'b1;
      end else begin
         normals_enable_ff <= normals_enable_in;
      end
   end

   tnt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .vertex_index_a (req_vertex_index_a),
      .vertex_index_b (req_vertex_index_b),
      .vertex_index_c (req_vertex_index_c),
      .position_a     (req_position_a),
      .position_b     (req_position_b),
      .position_c     (req_position_c),
      .texcoord_a     (req_texcoord_a),
      .texcoord_b     (req_texcoord_b),
      .texcoord_c     (req_texcoord_c),
      .q_full         (q_full),
      .busy           (busy),
      .push           (push),
      .push_data      (push_data)
   );

   tnt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   tnt_norm #(.TAG_W(TAG_W)) u_norm_n (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pop),
      .in_mag     (head.n_mag),
      .in_neg     (head.n_neg),
      .in_tag     ({head.idx_c, head.idx_b, head.idx_a}),
      .out_valid  (n_valid),
      .out_packed (n_packed),
      .out_tag    (n_tag)
   );

   tnt_norm #(.TAG_W(1)) u_norm_t (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pop),
      .in_mag     (head.t_mag),
      .in_neg     (head.t_neg),
      .in_tag     (head.degenerate),
      .out_valid  (t_valid),
      .out_packed (t_packed),
      .out_tag    (t_tag)
   );

   assign rsp_valid              = n_valid && t_valid;
   assign rsp_out_index_a        = n_tag[tnt_pkg::IDX_W-1:0] & IDX_MASK;
   assign rsp_out_index_b        = n_tag[2*tnt_pkg::IDX_W-1:tnt_pkg::IDX_W] & IDX_MASK;
   assign rsp_out_index_c        = n_tag[3*tnt_pkg::IDX_W-1:2*tnt_pkg::IDX_W] & IDX_MASK;
   assign rsp_unit_normal        = normals_enable_ff ? n_packed : '0;
   assign rsp_unit_tangent       = t_tag ? '0 : t_packed;
   assign rsp_tangent_degenerate = t_tag;

endmodule

>>> verif/tb_triangle_normal_tangent.sv
`timescale 1ns / 1ps

module tb_triangle_normal_tangent;

   localparam int PIPE_LAT = 57;

   typedef struct {
      logic [15:0] ia, ib, ic;
      logic [47:0] nrm, tan;
      logic        degen;
   } face_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_vertex_index_a = '0, req_vertex_index_b = '0, req_vertex_index_c = '0;
   logic [47:0] req_position_a = '0, req_position_b = '0, req_position_c = '0;
   logic [31:0] req_texcoord_a = '0, req_texcoord_b = '0, req_texcoord_c = '0;
   logic        rsp_valid;
   logic [15:0] rsp_out_index_a, rsp_out_index_b, rsp_out_index_c;
   logic [47:0] rsp_unit_normal, rsp_unit_tangent;
   logic        rsp_tangent_degenerate;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [tnt_pkg::ADDR_W-1:0] paddr = '0;
   logic [tnt_pkg::DATA_W-1:0] pwdata = '0;
   logic [tnt_pkg::DATA_W-1:0] prdata;
   logic        pready;

   face_type face_tab[int];
   bit    nrm_en;
   int    errors = 0;
   int    n_sent = 0;
   int    n_seen = 0;
   int    n_degen = 0;

   triangle_normal_tangent dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [47:0] unitize(longint c0, longint c1, longint c2);
      longint      c[3];
      logic [63:0] mag[3];
      bit          neg[3];
      logic [63:0] top, sum, len, q;
      logic [47:0] packed_v;
      c[0] = c0; c[1] = c1; c[2] = c2;
      top = 0; sum = 0; packed_v = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i] < 0;
         mag[i] = neg[i] ? -c[i] : c[i];
         if (mag[i] > top) top = mag[i];
      end
      if (top == 0) return '0;
      while (top >= (64'd1 << 30)) begin
         top >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (top < (64'd1 << 29)) begin
         top <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * tnt_pkg::UNIT_ONE + (len >> 1)) / len;
         if (q > tnt_pkg::UNIT_ONE) q = tnt_pkg::UNIT_ONE;
         if (neg[i]) q = (64'h10000 - q) & 64'hFFFF;
         packed_v[16*i +: 16] = q[15:0];
      end
      return packed_v;
   endfunction

   function automatic face_type predict_face(logic [15:0] ia, ib, ic, logic [47:0] pa, pb, pc,
                                             logic [31:0] ta, tb, tc);
      face_type f;
      longint e1[3], e2[3], t[3];
      longint du1, dv1, du2, dv2, det, v;
      for (int i = 0; i < 3; i++) begin
         e1[i] = longint'($signed(pb[16*i +: 16])) - longint'($signed(pa[16*i +: 16]));
         e2[i] = longint'($signed(pc[16*i +: 16])) - longint'($signed(pa[16*i +: 16]));
      end
      du1 = longint'(tb[15:0]) - longint'(ta[15:0]);
      dv1 = longint'(tb[31:16]) - longint'(ta[31:16]);
      du2 = longint'(tc[15:0]) - longint'(ta[15:0]);
      dv2 = longint'(tc[31:16]) - longint'(ta[31:16]);
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
         v = dv2 * e1[i] - dv1 * e2[i];
         t[i] = (det < 0) ? -v : v;
      end
      f.ia = ia; f.ib = ib; f.ic = ic;
      f.nrm = nrm_en ? unitize(e1[1]*e2[2] - e1[2]*e2[1], e1[2]*e2[0] - e1[0]*e2[2],
                               e1[0]*e2[1] - e1[1]*e2[0]) : '0;
      f.tan = (det == 0) ? '0 : unitize(t[0], t[1], t[2]);
      f.degen = (det == 0);
      return f;
   endfunction

   task automatic send_triangle(logic [15:0] ia, ib, ic, logic [47:0] pa, pb, pc,
                                logic [31:0] ta, tb, tc);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_vertex_index_a <= ia; req_vertex_index_b <= ib; req_vertex_index_c <= ic;
      req_position_a <= pa; req_position_b <= pb; req_position_c <= pc;
      req_texcoord_a <= ta; req_texcoord_b <= tb; req_texcoord_c <= tc;
      do @(posedge clock); while (busy);
      face_tab[n_sent] = predict_face(ia, ib, ic, pa, pb, pc, ta, tb, tc);
      n_sent++;
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (n_seen != n_sent) @(posedge clock);
      repeat (PIPE_LAT + 5) @(posedge clock);
   endtask

   task automatic csr_write(logic [tnt_pkg::ADDR_W-1:0] a, logic [31:0] d);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (a == tnt_pkg::ADDR_W'(4*tnt_pkg::REG_NORMALS_ENABLE)) nrm_en = d[0];
   endtask

   function automatic logic [47:0] rnd_pos(int span);
      logic [47:0] p;
      for (int i = 0; i < 3; i++)
         p[16*i +: 16] = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2*span) - span);
      return p;
   endfunction

   task automatic send_random(int span);
      logic [31:0] ta, tb, tc;
      ta = $urandom; tb = $urandom; tc = $urandom;
      case ($urandom_range(0, 7))
         0: tc = tb;
         1: tb = ta;
         2: begin
            tb = {ta[31:16] + 16'd1, ta[15:0] + 16'd2};
            tc = {ta[31:16] + 16'd2, ta[15:0] + 16'd4};
         end
         default: ;
      endcase
      send_triangle(16'($urandom), 16'($urandom), 16'($urandom),
                    rnd_pos(span), rnd_pos(span), rnd_pos(span), ta, tb, tc);
   endtask

   task automatic test_directed;
      send_triangle(16'h0000, 16'h0001, 16'h0002, 48'h0000_0000_0000, 48'h0000_0000_0010,
                    48'h0000_0010_0000, 32'h0000_0000, 32'h0000_8000, 32'h8000_0000);
      send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF, 48'h0, 48'h0, 48'h0, 32'h0, 32'h0, 32'h0);
      send_triangle(16'h1234, 16'hABCD, 16'h8000, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                    48'h8000_7FFF_8000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF);
      send_triangle(16'h0003, 16'h0004, 16'h0005, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000,
                    48'h7FFF_7FFF_8000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000);
      send_triangle(16'h0007, 16'h0008, 16'h0009, 48'h0, 48'h0000_0000_0001, 48'h0000_0001_0000,
                    32'h0000_0000, 32'h0001_0001, 32'h0002_0002);
      send_triangle(16'h000A, 16'h000B, 16'h000C, 48'h0001_0001_0001, 48'h0002_0002_0002,
                    48'h0003_0003_0003, 32'h0000_0000, 32'h0000_0001, 32'h0001_0000);
      send_triangle(16'h5555, 16'hAAAA, 16'h0F0F, 48'h0, 48'h0000_0000_0010, 48'h0000_0010_0000,
                    32'h8000_8000, 32'h8000_0000, 32'h0000_8000);
      for (int k = 0; k < 10; k++) send_random(0);
      drain();
   endtask

   task automatic test_normals_off;
      csr_write(tnt_pkg::ADDR_W'(4*tnt_pkg::REG_NORMALS_ENABLE), 32'h0);
      send_triangle(16'h0001, 16'h0002, 16'h0003, 48'h0, 48'h0000_0000_0010,
                    48'h0000_0010_0000, 32'h0, 32'h0000_8000, 32'h8000_0000);
      for (int k = 0; k < 150; k++) send_random($urandom_range(0, 1) ? 0 : 64);
      drain();
      csr_write(tnt_pkg::ADDR_W'(4*tnt_pkg::REG_NORMALS_ENABLE), 32'hFFFF_FFFE);
      for (int k = 0; k < 50; k++) send_random(0);
      drain();
      csr_write(tnt_pkg::ADDR_W'(4*tnt_pkg::REG_NORMALS_ENABLE), 32'h1);
   endtask

   task automatic test_random;
      int span;
      for (int k = 0; k < 900; k++) begin
         case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 4;
            2: span = 200;
            default: span = 2000;
         endcase
         send_random(span);
      end
      drain();
   endtask

   always @(posedge clock) begin
      face_type f;
      if (!reset && rsp_valid) begin
         if (n_seen == n_sent) begin
            $error("result with no triangle outstanding");
            errors++;
         end else begin
            f = face_tab[n_seen];
            face_tab.delete(n_seen);
            n_seen++;
            if (f.degen) n_degen++;
            if (rsp_out_index_a !== f.ia) begin
               $error("out_index_a exp %h got %h", f.ia, rsp_out_index_a); errors++;
            end
            if (rsp_out_index_b !== f.ib) begin
               $error("out_index_b exp %h got %h", f.ib, rsp_out_index_b); errors++;
            end
            if (rsp_out_index_c !== f.ic) begin
               $error("out_index_c exp %h got %h", f.ic, rsp_out_index_c); errors++;
            end
            if (rsp_unit_normal !== f.nrm) begin
               $error("unit_normal exp %h got %h", f.nrm, rsp_unit_normal); errors++;
            end
            if (rsp_unit_tangent !== f.tan) begin
               $error("unit_tangent exp %h got %h", f.tan, rsp_unit_tangent); errors++;
            end
            if (rsp_tangent_degenerate !== f.degen) begin
               $error("tangent_degenerate exp %b got %b", f.degen, rsp_tangent_degenerate);
               errors++;
            end
         end
      end
   end

   initial begin
      nrm_en = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_normals_off();
      test_random();
      if (n_seen != n_sent) begin
         $error("%0d results never arrived", n_sent - n_seen);
         errors++;
      end
      $display("Sent %0d triangles, checked %0d results (%0d with zero UV determinant),",
               n_sent, n_seen, n_degen);
      $display("normals enabled and disabled, extremes and random geometry.");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
